>>> src/acd_pkg.sv
// Shared types and constants for the arm contact error detector.
package acd_pkg;

  localparam int unsigned AngleW = 16;
  localparam int unsigned CfgW   = 14;
  localparam int unsigned DelayW = 3;
  localparam int unsigned CfgIdxW = 3;

  // Register reset values.
  localparam logic [CfgW-1:0]   PitchThrRst   = 14'd960;
  localparam logic [CfgW-1:0]   RollThrRst    = 14'd480;
  localparam logic [CfgW-1:0]   PitchDecayRst = 14'd512;
  localparam logic [CfgW-1:0]   RollDecayRst  = 14'd384;
  localparam logic [DelayW-1:0] DelayRst      = 3'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PITCH_THR   = 3'd0,
    CFG_ROLL_THR    = 3'd1,
    CFG_PITCH_DECAY = 3'd2,
    CFG_ROLL_DECAY  = 3'd3,
    CFG_DELAY       = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    POSTURE_UPRIGHT  = 2'd0,
    POSTURE_STAGGER  = 2'd1,
    POSTURE_GROUND   = 2'd2,
    POSTURE_OTHER    = 2'd3
  } posture_e;

  // One set of shoulder angles.
  typedef struct packed {
    logic signed [AngleW-1:0] lp;
    logic signed [AngleW-1:0] lr;
    logic signed [AngleW-1:0] rp;
    logic signed [AngleW-1:0] rr;
  } angle_set_t;

  typedef struct packed {
    angle_set_t cmd;
    angle_set_t meas;
    posture_e   posture;
    logic       motion_ok;
  } frame_t;

  // Per-frame control shared by the four accumulators.
  typedef struct packed {
    logic advance;  // frame is being processed this cycle
    logic clear;    // on-ground, drop the accumulated error
    logic gate;     // add tracking error this frame
  } axis_ctrl_t;

endpackage

>>> src/acd_hist.sv
// Command delay line: shift register of past commands with a selectable tap.
module acd_hist #(
  parameter int unsigned Depth = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [acd_pkg::DelayW-1:0]  delay_i,
  input  acd_pkg::angle_set_t         cmd_i,
  output acd_pkg::angle_set_t         cmd_dly_o
);
  import acd_pkg::*;

  localparam int unsigned Entries = Depth - 1;
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1;

  angle_set_t hist_q [Entries];

  logic [6:0]      dly_ext;
  logic [6:0]      dly_sat;
  logic [6:0]      dly_m1;
  logic [IdxW-1:0] tap_idx;

  // hist_q[0] is the previous frame's command, hist_q[k] is k+1 frames back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Entries; k++) begin
        hist_q[k] <= '0;
      end
    end else if (shift_i) begin
      hist_q[0] <= cmd_i;
      for (int k = 1; k < Entries; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  always_comb begin
    dly_ext = {{(7-DelayW){1'b0}}, delay_i};
    dly_sat = (dly_ext > 7'(Entries)) ? 7'(Entries) : dly_ext;
    dly_m1  = dly_sat - 7'd1;
    tap_idx = dly_m1[IdxW-1:0];
    if (dly_sat == 7'd0) begin
      cmd_dly_o = cmd_i;
    end else begin
      cmd_dly_o = hist_q[tap_idx];
    end
  end

endmodule

>>> src/acd_axis.sv
// One error accumulator: decay, ground clear, saturating add of tracking error.
module acd_axis #(
  parameter int unsigned ErrorCap = 11520,
  parameter int unsigned ErrW     = $clog2(ErrorCap + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  acd_pkg::axis_ctrl_t               ctrl_i,
  input  logic [acd_pkg::CfgW-1:0]          decay_i,
  input  logic signed [acd_pkg::AngleW-1:0] cmd_i,
  input  logic signed [acd_pkg::AngleW-1:0] meas_i,
  output logic [ErrW-1:0]                   err_d_o,
  output logic [ErrW-1:0]                   err_q_o
);
  import acd_pkg::*;

  localparam int unsigned SumW = 18;

  logic [ErrW-1:0]          err_q;
  logic [SumW-1:0]          err_ext;
  logic [SumW-1:0]          dec_ext;
  logic [SumW-1:0]          decayed;
  logic signed [AngleW:0]   diff;
  logic [AngleW:0]          mag;
  logic [SumW-1:0]          sum;
  logic [SumW-1:0]          result;

  always_comb begin
    err_ext = {{(SumW-ErrW){1'b0}}, err_q};
    dec_ext = {{(SumW-CfgW){1'b0}}, decay_i};
    decayed = (err_ext > dec_ext) ? (err_ext - dec_ext) : '0;
    if (ctrl_i.clear) begin
      decayed = '0;
    end
    diff = {cmd_i[AngleW-1], cmd_i} - {meas_i[AngleW-1], meas_i};
    mag  = diff[AngleW] ? -diff : diff;
    sum  = decayed + {{(SumW-AngleW-1){1'b0}}, mag};
    if (ctrl_i.gate) begin
      result = (sum > SumW'(ErrorCap)) ? SumW'(ErrorCap) : sum;
    end else begin
      result = decayed;
    end
    err_d_o = result[ErrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= '0;
    end else if (ctrl_i.advance) begin
      err_q <= err_d_o;
    end
  end

  assign err_q_o = err_q;

endmodule

>>> src/arm_contact_error_detector_top.sv
// Top level of the arm contact error detector.
//
// Each input transfer is one frame: commanded and measured pitch and roll of
// both shoulders (1/128 degree, signed), a posture code and a motion gate.
// The commands enter a delay line and the command delay_frames frames back
// (0 = this frame, clipped to HISTORY_DEPTH-1) is compared to the measurement.
// Four accumulators decay by pitch_decay / roll_decay every frame (floor 0),
// clear on ground, and while the gate is open (motion_ok and upright or
// staggering) add |delayed cmd - meas|, saturating at ERROR_CAP. A side
// reports contact when either axis error exceeds its threshold; with the
// gate closed both contacts read 0. One result transfer per frame.
// Throughput is one frame per clock while m_axis_tready_i is high, set by
// the combinational accumulator update between the two registers. A frame
// passes the input register, then the result register, before its result
// is offered. A result waiting on m_axis_tready_i holds the input register,
// so the input stalls once both registers are full (two frames in flight).
// Registers come out of reset with their documented values; no init pass.
// Config writes are always accepted and must only happen while idle.
module arm_contact_error_detector_top #(
  parameter int unsigned HISTORY_DEPTH = 8,
  parameter int unsigned ERROR_CAP     = 11520
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // frame input
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [15:0] cmd_left_pitch, [31:16] cmd_left_roll, [47:32] cmd_right_pitch,
  // [63:48] cmd_right_roll, [79:64] meas_left_pitch, [95:80] meas_left_roll,
  // [111:96] meas_right_pitch, [127:112] meas_right_roll
  input  logic [127:0] s_axis_tdata_i,
  // [1:0] posture, [2] motion_ok
  input  logic [2:0]   s_axis_tuser_i,
  // contact result
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [0] contact_left, [1] contact_right, [7:2] zero
  output logic [7:0]   m_axis_tdata_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [acd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [acd_pkg::CfgW-1:0]      cfg_data_i
);
  import acd_pkg::*;

  localparam int unsigned ErrW = $clog2(ERROR_CAP + 1);
  localparam int unsigned CmpW = 18;

  // config registers
  logic [CfgW-1:0]   pitch_thr_q, roll_thr_q, pitch_decay_q, roll_decay_q;
  logic [DelayW-1:0] delay_q;

  // input stage
  logic   in_valid_q, in_valid_d;
  frame_t in_q, in_d;
  logic   s_xfer;

  // result stage
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_q;

  logic       advance;
  axis_ctrl_t ctrl;
  angle_set_t cmd_dly;
  logic       contact_left, contact_right;

  logic [ErrW-1:0] lp_d, lr_d, rp_d, rr_d;
  logic [ErrW-1:0] lp_q, lr_q, rp_q, rr_q;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_thr_q   <= PitchThrRst;
      roll_thr_q    <= RollThrRst;
      pitch_decay_q <= PitchDecayRst;
      roll_decay_q  <= RollDecayRst;
      delay_q       <= DelayRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PITCH_THR:   pitch_thr_q   <= cfg_data_i;
        CFG_ROLL_THR:    roll_thr_q    <= cfg_data_i;
        CFG_PITCH_DECAY: pitch_decay_q <= cfg_data_i;
        CFG_ROLL_DECAY:  roll_decay_q  <= cfg_data_i;
        CFG_DELAY:       delay_q       <= cfg_data_i[DelayW-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------- handshaking
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d        = s_xfer || (in_valid_q && !advance);
    out_valid_d       = advance || (out_valid_q && !m_axis_tready_i);
    in_d.cmd.lp       = s_axis_tdata_i[15:0];
    in_d.cmd.lr       = s_axis_tdata_i[31:16];
    in_d.cmd.rp       = s_axis_tdata_i[47:32];
    in_d.cmd.rr       = s_axis_tdata_i[63:48];
    in_d.meas.lp      = s_axis_tdata_i[79:64];
    in_d.meas.lr      = s_axis_tdata_i[95:80];
    in_d.meas.rp      = s_axis_tdata_i[111:96];
    in_d.meas.rr      = s_axis_tdata_i[127:112];
    in_d.posture      = posture_e'(s_axis_tuser_i[1:0]);
    in_d.motion_ok    = s_axis_tuser_i[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= {contact_right, contact_left};
    end
  end

  // -------------------------------------------------------------- datapath
  always_comb begin
    ctrl.advance = advance;
    ctrl.clear   = (in_q.posture == POSTURE_GROUND);
    ctrl.gate    = in_q.motion_ok &&
                   (in_q.posture inside {POSTURE_UPRIGHT, POSTURE_STAGGER});
  end

  acd_hist #(
    .Depth (HISTORY_DEPTH)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (advance),
    .delay_i   (delay_q),
    .cmd_i     (in_q.cmd),
    .cmd_dly_o (cmd_dly)
  );

  acd_axis #(.ErrorCap(ERROR_CAP), .ErrW(ErrW)) u_axis_lp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .decay_i(pitch_decay_q),
    .cmd_i(cmd_dly.lp), .meas_i(in_q.meas.lp), .err_d_o(lp_d), .err_q_o(lp_q)
  );

  acd_axis #(.ErrorCap(ERROR_CAP), .ErrW(ErrW)) u_axis_lr (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .decay_i(roll_decay_q),
    .cmd_i(cmd_dly.lr), .meas_i(in_q.meas.lr), .err_d_o(lr_d), .err_q_o(lr_q)
  );

  acd_axis #(.ErrorCap(ERROR_CAP), .ErrW(ErrW)) u_axis_rp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .decay_i(pitch_decay_q),
    .cmd_i(cmd_dly.rp), .meas_i(in_q.meas.rp), .err_d_o(rp_d), .err_q_o(rp_q)
  );

  acd_axis #(.ErrorCap(ERROR_CAP), .ErrW(ErrW)) u_axis_rr (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .decay_i(roll_decay_q),
    .cmd_i(cmd_dly.rr), .meas_i(in_q.meas.rr), .err_d_o(rr_d), .err_q_o(rr_q)
  );

  // contact compares use the freshly updated errors
  always_comb begin
    contact_left  = ctrl.gate &&
                    ((CmpW'(lp_d) > CmpW'(pitch_thr_q)) || (CmpW'(lr_d) > CmpW'(roll_thr_q)));
    contact_right = ctrl.gate &&
                    ((CmpW'(rp_d) > CmpW'(pitch_thr_q)) || (CmpW'(rr_d) > CmpW'(roll_thr_q)));
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_q};

  // ------------------------------------------------------------ assertions
  // accumulators never pass the cap
  a_err_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CmpW'(lp_q) <= CmpW'(ERROR_CAP)) && (CmpW'(lr_q) <= CmpW'(ERROR_CAP)) &&
    (CmpW'(rp_q) <= CmpW'(ERROR_CAP)) && (CmpW'(rr_q) <= CmpW'(ERROR_CAP)))
    else $error("error accumulator above cap");

  // an on-ground frame leaves every accumulator at zero
  a_ground_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ctrl.clear |=> (lp_q == '0) && (lr_q == '0) && (rp_q == '0) && (rr_q == '0))
    else $error("accumulators not cleared on ground");

  // a frame with the gate closed reports no contact
  a_gate_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !ctrl.gate |=> (m_axis_tdata_o[1:0] == 2'b00))
    else $error("contact reported with gate closed");

  // an empty input stage always takes a transfer
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input stalled while empty");

endmodule

>>> test/arm_contact_error_detector_top_tb.sv
// Self-checking testbench for the arm contact error detector top level.
`timescale 1ns / 100ps

module arm_contact_error_detector_top_tb;
  import acd_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int Depth         = 8;
  localparam int Cap           = 11520;
  localparam int AngMax        = 23040;
  localparam int AngMin        = -23040;
  localparam int FullMax       = 32767;
  localparam int FullMin       = -32768;
  localparam int MaxIdle       = 6;
  localparam int ItemsPerPhase = 180;
  // Spare cycles after the drain, before any register write.
  localparam int SettleCycles  = 6;
  // Receiver hold-off, long enough to back the block up into its input.
  localparam int HoldAfter     = 300;
  localparam int HoldCycles    = 200;
  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int StallLimit    = 3000;

  // One directed frame; known marks rows whose result is typed in by hand.
  typedef struct {
    angle_set_t cmd;
    angle_set_t meas;
    posture_e   pst;
    logic       mot;
    logic       known;
    logic [1:0] contact;  // [0] left, [1] right
  } probe_t;

  typedef struct {
    logic [CfgW-1:0] thr_p;
    logic [CfgW-1:0] thr_r;
    logic [CfgW-1:0] dec_p;
    logic [CfgW-1:0] dec_r;
    logic [DelayW-1:0] dly;
  } setting_t;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_valid;
  logic                s_ready;
  logic [127:0]        s_data;
  logic [2:0]          s_user;
  logic                m_valid;
  logic                m_ready;
  logic [7:0]          m_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;

  arm_contact_error_detector_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Contact predictor: own copy of registers, command history and accumulators
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0]   pitch_thr, roll_thr, pitch_dec, roll_dec;
  logic [DelayW-1:0] delay_cfg;
  angle_set_t        cmd_hist [Depth];
  int unsigned       hist_wr;
  logic [CfgW-1:0]   axis_err [4];  // left pitch, left roll, right pitch, right roll

  logic [1:0]        expected_contacts [$];

  int fails;
  int frames_sent;
  int results_seen;
  int cfg_writes;
  int phases_run;
  int left_hits, right_hits;
  bit held_off;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  // Advance the predictor by one frame and return {right, left} contact.
  task automatic predict_contacts(input angle_set_t cmd, input angle_set_t meas,
                                  input posture_e pst, input logic mot,
                                  output logic [1:0] contact);
    logic signed [AngleW-1:0] c_old [4];
    logic signed [AngleW-1:0] m_now [4];
    angle_set_t old;
    int unsigned d, rd;
    int diff, mag, sum;
    logic gate;
    logic [CfgW-1:0] dec, thr;
    cmd_hist[hist_wr] = cmd;
    d = (delay_cfg > Depth - 1) ? Depth - 1 : delay_cfg;
    rd = (hist_wr + Depth - d) % Depth;
    old = cmd_hist[rd];
    hist_wr = (hist_wr + 1) % Depth;
    c_old = '{old.lp, old.lr, old.rp, old.rr};
    m_now = '{meas.lp, meas.lr, meas.rp, meas.rr};
    gate = mot && (pst == POSTURE_UPRIGHT || pst == POSTURE_STAGGER);
    contact = 2'b00;
    for (int a = 0; a < 4; a++) begin
      // even axes are pitch, odd axes roll
      dec = (a % 2 == 0) ? pitch_dec : roll_dec;
      thr = (a % 2 == 0) ? pitch_thr : roll_thr;
      axis_err[a] = (axis_err[a] > dec) ? axis_err[a] - dec : '0;
      if (pst == POSTURE_GROUND) axis_err[a] = '0;
      if (gate) begin
        // full-precision difference, saturate only the sum
        diff = int'(c_old[a]) - int'(m_now[a]);
        mag = (diff < 0) ? -diff : diff;
        sum = int'(axis_err[a]) + mag;
        axis_err[a] = (sum > Cap) ? CfgW'(Cap) : CfgW'(sum);
        if (axis_err[a] > thr) contact[a / 2] = 1'b1;
      end
    end
  endtask

  function automatic angle_set_t angles(input int lp, input int lr, input int rp, input int rr);
    angle_set_t v;
    v.lp = AngleW'(lp);
    v.lr = AngleW'(lr);
    v.rp = AngleW'(rp);
    v.rr = AngleW'(rr);
    return v;
  endfunction

  function automatic probe_t probe(input angle_set_t cmd, input angle_set_t meas,
                                   input posture_e pst, input logic mot,
                                   input logic known, input logic [1:0] contact);
    probe_t p;
    p.cmd = cmd;
    p.meas = meas;
    p.pst = pst;
    p.mot = mot;
    p.known = known;
    p.contact = contact;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Frame sender: random gap, offer, wait for the transfer, then predict.
  // Returns in the step of the accepting edge with tvalid still high.
  // ---------------------------------------------------------------------------
  task automatic send_frame(input angle_set_t cmd, input angle_set_t meas,
                            input posture_e pst, input logic mot,
                            input logic known, input logic [1:0] typed);
    int gap;
    logic [1:0] want;
    // every fourth stretch of 80 frames is sent back to back
    gap = (((frames_sent / 80) % 4) == 3) ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_data  <= {meas.rr, meas.rp, meas.lr, meas.lp, cmd.rr, cmd.rp, cmd.lr, cmd.lp};
    s_user  <= {mot, pst};
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_ready);
    predict_contacts(cmd, meas, pst, mot, want);
    if (known) want = typed;
    expected_contacts.push_back(want);
    left_hits  += want[0];
    right_hits += want[1];
    frames_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // out-of-range indexes are dropped by the block, so no update here
    case (idx)
      CFG_PITCH_THR:   pitch_thr = data;
      CFG_ROLL_THR:    roll_thr  = data;
      CFG_PITCH_DECAY: pitch_dec = data;
      CFG_ROLL_DECAY:  roll_dec  = data;
      CFG_DELAY:       delay_cfg = data[DelayW-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Drain the pipeline, then load a full register set plus one spare index.
  task automatic apply_setting(input setting_t st);
    while (expected_contacts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(CFG_PITCH_THR, st.thr_p);
    write_reg(CFG_ROLL_THR, st.thr_r);
    write_reg(CFG_PITCH_DECAY, st.dec_p);
    write_reg(CFG_ROLL_DECAY, st.dec_r);
    // upper data bits are junk and must be dropped by the 3-bit register
    write_reg(CFG_DELAY, {(CfgW - DelayW)'($urandom), st.dly});
    write_reg(CfgIdxW'($urandom_range(int'(CFG_DELAY) + 1, 7)), CfgW'($urandom));
    phases_run++;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall per transfer, one long hold-off, in-order check
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    logic [1:0] want;
    m_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && results_seen >= HoldAfter) begin
        stall = HoldCycles;
        held_off = 1'b1;
      end else if (((results_seen / 70) % 4) == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MaxIdle);
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
      results_seen++;
      if (expected_contacts.size() == 0) begin
        report_mismatch("unexpected result transfer", int'(m_data), -1);
      end else begin
        want = expected_contacts.pop_front();
        if (m_data[0] != want[0]) report_mismatch("contact_left", m_data[0], want[0]);
        if (m_data[1] != want[1]) report_mismatch("contact_right", m_data[1], want[1]);
        if (m_data[7:2] != '0) report_mismatch("tdata padding", m_data[7:2], 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transfer on any channel resets the count
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_contacts.size());
        $display("arm_contact_error_detector_top_tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    probe_t probes [$];
    setting_t settings [$];
    setting_t st;
    int walk [4];
    int c [4];
    int m [4];
    int span, roll;
    posture_e pst;
    logic mot;

    rst_ni    = 1'b0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_user    = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    fails = 0;
    frames_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    phases_run = 0;
    left_hits = 0;
    right_hits = 0;
    held_off = 1'b0;

    // predictor mirrors the documented reset state
    pitch_thr = PitchThrRst;
    roll_thr  = RollThrRst;
    pitch_dec = PitchDecayRst;
    roll_dec  = RollDecayRst;
    delay_cfg = DelayRst;
    hist_wr   = 0;
    for (int i = 0; i < Depth; i++) cmd_hist[i] = '0;
    for (int a = 0; a < 4; a++) axis_err[a] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at reset settings (delay 2, thresholds 960 / 480).
    // quiet start: everything zero
    probes.push_back(probe(angles(0, 0, 0, 0), angles(0, 0, 0, 0),
                           POSTURE_UPRIGHT, 1'b1, 1'b1, 2'b00));
    // gate closed by motion: no contact whatever the angles
    probes.push_back(probe(angles(AngMax, AngMax, AngMax, AngMax), angles(0, 0, 0, 0),
                           POSTURE_UPRIGHT, 1'b0, 1'b1, 2'b00));
    // history still zero, max measurement: errors saturate, both sides hit
    probes.push_back(probe(angles(0, 0, 0, 0), angles(AngMax, AngMax, AngMax, AngMax),
                           POSTURE_UPRIGHT, 1'b1, 1'b1, 2'b11));
    // on ground clears everything
    probes.push_back(probe(angles(0, 0, 0, 0), angles(0, 0, 0, 0),
                           POSTURE_GROUND, 1'b1, 1'b1, 2'b00));
    // posture other: gate closed, accumulators decay but are not cleared
    probes.push_back(probe(angles(AngMin, AngMin, AngMin, AngMin),
                           angles(AngMin, AngMin, AngMin, AngMin),
                           POSTURE_OTHER, 1'b1, 1'b1, 2'b00));
    probes.push_back(probe(angles(0, 0, 0, 0), angles(0, 0, 0, 0),
                           POSTURE_STAGGER, 1'b1, 1'b0, 2'b00));
    // compares against the min command two frames back
    probes.push_back(probe(angles(AngMax, AngMin, AngMin, AngMax), angles(0, 0, 0, 0),
                           POSTURE_UPRIGHT, 1'b1, 1'b0, 2'b00));
    // full 16-bit extremes, the delayed compare reaching differences of 65535
    probes.push_back(probe(angles(FullMin, FullMin, FullMin, FullMin),
                           angles(FullMax, FullMax, FullMax, FullMax),
                           POSTURE_STAGGER, 1'b1, 1'b0, 2'b00));
    probes.push_back(probe(angles(FullMax, FullMax, FullMax, FullMax),
                           angles(FullMin, FullMin, FullMin, FullMin),
                           POSTURE_UPRIGHT, 1'b1, 1'b0, 2'b00));
    probes.push_back(probe(angles(0, 0, 0, 0), angles(FullMax, FullMin, FullMax, FullMin),
                           POSTURE_UPRIGHT, 1'b1, 1'b0, 2'b00));
    probes.push_back(probe(angles(0, 0, 0, 0), angles(0, 0, 0, 0),
                           POSTURE_GROUND, 1'b0, 1'b1, 2'b00));
    // just over vs exactly at the pitch threshold
    probes.push_back(probe(angles(0, 0, 0, 0), angles(961, 0, 960, 0),
                           POSTURE_UPRIGHT, 1'b1, 1'b0, 2'b00));
    probes.push_back(probe(angles(0, 0, 0, 0), angles(0, 865, 0, 864),
                           POSTURE_STAGGER, 1'b1, 1'b0, 2'b00));
    probes.push_back(probe(angles(16'sh5555, 16'sh2AAA, -21846, 10922),
                           angles(-10923, 21845, 16'sh2AAA, 16'sh5555),
                           POSTURE_STAGGER, 1'b0, 1'b1, 2'b00));
    probes.push_back(probe(angles(0, 0, 0, 0), angles(AngMin, AngMax, AngMin, AngMax),
                           POSTURE_OTHER, 1'b1, 1'b1, 2'b00));

    foreach (probes[i])
      send_frame(probes[i].cmd, probes[i].meas, probes[i].pst, probes[i].mot,
                 probes[i].known, probes[i].contact);
    s_valid <= 1'b0;

    // Register settings for the random phases: low and high extremes, full
    // register width, reset values, then random picks.
    settings.push_back('{thr_p: 0, thr_r: 0, dec_p: 0, dec_r: 0, dly: 0});
    settings.push_back('{thr_p: Cap, thr_r: Cap, dec_p: Cap, dec_r: Cap, dly: 7});
    settings.push_back('{thr_p: 14'h3FFF, thr_r: 14'h3FFF, dec_p: 0, dec_r: 14'h3FFF,
                         dly: 7});
    settings.push_back('{thr_p: PitchThrRst, thr_r: RollThrRst, dec_p: PitchDecayRst,
                         dec_r: RollDecayRst, dly: DelayRst});
    repeat (4) begin
      st.thr_p = CfgW'($urandom_range(0, 4000));
      st.thr_r = CfgW'($urandom_range(0, 4000));
      st.dec_p = CfgW'($urandom_range(0, 1500));
      st.dec_r = CfgW'($urandom_range(0, 1500));
      st.dly   = DelayW'($urandom_range(0, 7));
      settings.push_back(st);
    end

    for (int a = 0; a < 4; a++) walk[a] = 0;

    foreach (settings[p]) begin
      apply_setting(settings[p]);
      repeat (ItemsPerPhase) begin
        // commands follow a slow random walk so the delayed compare stays
        // mostly small; now and then a jump or a raw 16-bit value
        roll = $urandom_range(0, 99);
        for (int a = 0; a < 4; a++) begin
          if (roll < 8) walk[a] = $urandom_range(0, 2 * AngMax) - AngMax;
          else walk[a] += int'($urandom_range(0, 1024)) - 512;
          if (walk[a] > AngMax) walk[a] = AngMax;
          if (walk[a] < AngMin) walk[a] = AngMin;
          c[a] = walk[a];
          span = ($urandom_range(0, 9) < 5) ? 256 :
                 ($urandom_range(0, 9) < 6) ? 2048 : AngMax;
          m[a] = c[a] + int'($urandom_range(0, 2 * span)) - span;
          if (m[a] > AngMax) m[a] = AngMax;
          if (m[a] < AngMin) m[a] = AngMin;
          if (roll >= 97) begin
            c[a] = int'($signed(16'($urandom)));
            m[a] = int'($signed(16'($urandom)));
          end
        end
        roll = $urandom_range(0, 19);
        pst = (roll < 10) ? POSTURE_UPRIGHT :
              (roll < 15) ? POSTURE_STAGGER :
              (roll < 17) ? POSTURE_GROUND : POSTURE_OTHER;
        mot = ($urandom_range(0, 9) != 0);
        send_frame(angles(c[0], c[1], c[2], c[3]), angles(m[0], m[1], m[2], m[3]),
                   pst, mot, 1'b0, 2'b00);
      end
      s_valid <= 1'b0;
    end

    // Drain, then give the block its latency plus margin for stray results.
    while (expected_contacts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("frames %0d, results %0d, register settings %0d, register writes %0d",
             frames_sent, results_seen, phases_run + 1, cfg_writes);
    $display("predicted contacts left %0d right %0d, receiver hold-off %0d cycles, %0d errors",
             left_hits, right_hits, held_off ? HoldCycles : 0, fails);
    if (fails == 0) begin
      $display("arm_contact_error_detector_top_tb: PASS");
    end else begin
      $display("arm_contact_error_detector_top_tb: FAIL");
    end
    $finish;
  end

endmodule
